// File: hw/rtl/legendre_series_kernel_entry_defines.svh
// Assertion macros for the Legendre series kernel entry block.
// Used by the port checker; depends on nothing.
`ifndef LEGENDRE_SERIES_KERNEL_ENTRY_DEFINES_SVH
`define LEGENDRE_SERIES_KERNEL_ENTRY_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSK_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define LSK_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: hw/rtl/lsk_pkg.sv
// Shared constants and bus types for the Legendre series kernel entry.
// No dependencies.
`default_nettype none
package lsk_pkg;
   localparam int MAX_TERMS = 32;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int COEF_W    = $clog2(2 * MAX_TERMS);
   localparam int SUM_W     = 32 + $clog2(MAX_TERMS) + 1;
   localparam int NUM_W     = 32 + $clog2(3 * MAX_TERMS) + 1;
   localparam int RECIP_W   = 25;

   localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
   localparam logic signed [31:0] NEG_ONE_Q30 = -32'sd1073741824;
   localparam logic [24:0]        INV_4PI_Q28 = 25'd21361415;
   localparam logic signed [63:0] ENTRY_MAX   = 64'sd140737488355327;
   localparam logic signed [63:0] ENTRY_MIN   = -64'sd140737488355328;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic [31:0]        w;
   } in_bus_type;

   typedef struct packed {
      logic                    valid;
      logic signed [31:0]      c;
      logic signed [31:0]      p1;
      logic signed [31:0]      p2;
      logic signed [SUM_W-1:0] sum;
      logic [31:0]             w;
   } term_bus_type;
endpackage
`default_nettype wire

// File: hw/rtl/lsk_dot.sv
// Dot product of the two points and clamp to [-1, 1]; two stages.
// Depends on lsk_pkg.
`default_nettype none
module lsk_dot (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire lsk_pkg::in_bus_type  in_bus,
   output lsk_pkg::term_bus_type     out_bus
);
   import lsk_pkg::*;

   logic               v1_ff;
   logic signed [61:0] px_ff, py_ff, pz_ff;
   logic [31:0]        w1_ff;
   logic signed [63:0] px_in, py_in, pz_in;
   logic signed [63:0] dot;
   logic signed [63:0] cr;
   logic signed [31:0] c_in;
   term_bus_type       out_ff;

   assign px_in = in_bus.ax * in_bus.bx;
   assign py_in = in_bus.ay * in_bus.by;
   assign pz_in = in_bus.az * in_bus.bz;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         px_ff <= 62'(px_in >>> 2);
         py_ff <= 62'(py_in >>> 2);
         pz_ff <= 62'(pz_in >>> 2);
         w1_ff <= in_bus.w;
      end
   end

   always_comb begin
      dot = 64'(px_ff) + 64'(py_ff) + 64'(pz_ff);
      cr  = (dot + 64'sd134217728) >>> 28;
      if (cr > 64'(ONE_Q30)) begin
         c_in = ONE_Q30;
      end else if (cr < 64'(NEG_ONE_Q30)) begin
         c_in = NEG_ONE_Q30;
      end else begin
         c_in = 32'(cr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid <= v1_ff;
      end
      if (adv) begin
         out_ff.c   <= c_in;
         out_ff.p1  <= c_in;
         out_ff.p2  <= ONE_Q30;
         out_ff.sum <= SUM_W'(ONE_Q30) + SUM_W'(c_in);
         out_ff.w   <= w1_ff;
      end
   end

   assign out_bus = out_ff;
endmodule
`default_nettype wire

// File: hw/rtl/lsk_term.sv
// One step of the Legendre recurrence in two stages: c*P(l-1), then divide by l.
// Depends on lsk_pkg.
`default_nettype none
module lsk_term (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic [lsk_pkg::COEF_W-1:0]  coef_a,
   input  wire logic [lsk_pkg::COEF_W-1:0]  coef_b,
   input  wire logic [lsk_pkg::RECIP_W-1:0] recip,
   input  wire logic [lsk_pkg::CNT_W-1:0]   degree,
   input  wire logic [lsk_pkg::CNT_W-1:0]   n_terms,
   input  wire lsk_pkg::term_bus_type       in_bus,
   output lsk_pkg::term_bus_type            out_bus
);
   import lsk_pkg::*;

   localparam int PROD_W = NUM_W + RECIP_W + 1;

   term_bus_type              a_ff;
   logic signed [31:0]        t_ff;
   logic signed [63:0]        cp;
   logic signed [NUM_W-1:0]   num;
   logic signed [PROD_W-1:0]  q;
   logic signed [PROD_W-1:0]  qr;
   logic signed [31:0]        p;
   logic                      active;
   term_bus_type              out_ff;

   assign cp = in_bus.c * in_bus.p1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
      end else if (adv) begin
         a_ff.valid <= in_bus.valid;
      end
      if (adv) begin
         a_ff.c   <= in_bus.c;
         a_ff.p1  <= in_bus.p1;
         a_ff.p2  <= in_bus.p2;
         a_ff.sum <= in_bus.sum;
         a_ff.w   <= in_bus.w;
         t_ff     <= 32'((cp + 64'sd536870912) >>> 30);
      end
   end

   always_comb begin
      num = $signed({1'b0, coef_a}) * NUM_W'(t_ff)
          - $signed({1'b0, coef_b}) * NUM_W'(a_ff.p2);
      q   = PROD_W'(num) * $signed({1'b0, recip});
      qr  = (q + PROD_W'(26'sd16777216)) >>> 25;
      if (qr > PROD_W'(ONE_Q30)) begin
         p = ONE_Q30;
      end else if (qr < PROD_W'(NEG_ONE_Q30)) begin
         p = NEG_ONE_Q30;
      end else begin
         p = 32'(qr);
      end
      active = degree < n_terms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         out_ff.valid <= a_ff.valid;
      end
      if (adv) begin
         out_ff.c <= a_ff.c;
         out_ff.w <= a_ff.w;
         if (active) begin
            out_ff.p1  <= p;
            out_ff.p2  <= a_ff.p1;
            out_ff.sum <= a_ff.sum + SUM_W'(p);
         end else begin
            out_ff.p1  <= a_ff.p1;
            out_ff.p2  <= a_ff.p2;
            out_ff.sum <= a_ff.sum;
         end
      end
   end

   assign out_bus = out_ff;
endmodule
`default_nettype wire

// File: hw/rtl/lsk_scale.sv
// Scale by 1/(4*pi) and the weight, round and saturate; three stages.
// Depends on lsk_pkg.
`default_nettype none
module lsk_scale (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  adv,
   input  wire lsk_pkg::term_bus_type in_bus,
   output logic                       out_valid,
   output logic signed [47:0]         out_entry
);
   import lsk_pkg::*;

   localparam int SK_W = SUM_W + 26;
   localparam int MW_W = SUM_W + 17;

   logic                    v1_ff, v2_ff, v3_ff;
   logic signed [SUM_W-1:0] m_ff;
   logic [31:0]             w_ff;
   logic signed [MW_W-1:0]  hi_ff, lo_ff;
   logic signed [47:0]      e_ff;
   logic signed [SK_W-1:0]  sk;
   logic signed [MW_W-1:0]  hi_in, lo_in;
   logic signed [63:0]      e_wide;
   logic signed [47:0]      e_in;

   assign sk    = SK_W'(in_bus.sum) * $signed({1'b0, INV_4PI_Q28});
   assign hi_in = MW_W'(m_ff) * $signed({1'b0, w_ff[31:16]});
   assign lo_in = MW_W'(m_ff) * $signed({1'b0, w_ff[15:0]});

   always_comb begin
      e_wide = (64'(hi_ff) + 64'(lo_ff >>> 16) + 64'sd4096) >>> 13;
      if (e_wide > ENTRY_MAX) begin
         e_in = 48'(ENTRY_MAX);
      end else if (e_wide < ENTRY_MIN) begin
         e_in = 48'(ENTRY_MIN);
      end else begin
         e_in = 48'(e_wide);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         m_ff  <= SUM_W'((sk + SK_W'(27'sd33554432)) >>> 26);
         w_ff  <= in_bus.w;
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         e_ff  <= e_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_entry = e_ff;
endmodule
`default_nettype wire

// File: hw/rtl/legendre_series_kernel_entry.sv
// Top level of the Legendre series kernel entry: register port and pipeline.
// Depends on lsk_pkg, lsk_dot, lsk_term, lsk_scale.
`default_nettype none
// Takes one point pair and weight per beat and returns one Q15.32 matrix entry
// per beat, in order. The pipeline accepts a new beat every cycle unless it is
// held; it has two dot-product stages, two stages per recurrence degree
// 2..MAX_TERMS-1 and three scaling stages. The whole pipeline holds while a
// finished entry waits on rsp_ready. number_of_terms sits at byte address 0;
// the user must write it only while idle, as the block does not enforce this.
module legendre_series_kernel_entry (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_first_x,
   input  wire logic signed [31:0] req_first_y,
   input  wire logic signed [31:0] req_first_z,
   input  wire logic signed [31:0] req_second_x,
   input  wire logic signed [31:0] req_second_y,
   input  wire logic signed [31:0] req_second_z,
   input  wire logic [31:0]        req_column_weight,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [47:0]      rsp_entry,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import lsk_pkg::*;

   localparam logic ADDR_TERMS = 1'b0;

   logic [5:0]       terms_ff;
   logic [CNT_W-1:0] n_eff;
   logic             adv;
   in_bus_type       in_bus;
   term_bus_type     chain [MAX_TERMS-1];

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ADDR_TERMS) ? {26'd0, terms_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         terms_ff <= 6'd8;
      end else if (psel && penable && pwrite && (paddr[2] == ADDR_TERMS)) begin
         terms_ff <= pwdata[5:0];
      end
   end

   assign n_eff = ({2'd0, terms_ff} > 8'(MAX_TERMS)) ? CNT_W'(MAX_TERMS)
                                                      : CNT_W'(terms_ff);

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign in_bus = '{ax: req_first_x, ay: req_first_y, az: req_first_z,
                     bx: req_second_x, by: req_second_y, bz: req_second_z,
                     w: req_column_weight};

   lsk_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_bus   (in_bus),
      .out_bus  (chain[0])
   );

   for (genvar i = 0; i < MAX_TERMS - 2; i++) begin : g_term
      localparam int L = i + 2;
      localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((33554432 + L / 2) / L);
      lsk_term u_term (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .coef_a  (COEF_W'(2 * L - 1)),
         .coef_b  (COEF_W'(L - 1)),
         .recip   (RECIP),
         .degree  (CNT_W'(L)),
         .n_terms (n_eff),
         .in_bus  (chain[i]),
         .out_bus (chain[i+1])
      );
   end

   lsk_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_bus    (chain[MAX_TERMS-2]),
      .out_valid (rsp_valid),
      .out_entry (rsp_entry)
   );
endmodule
`default_nettype wire

// File: hw/rtl/lsk_checker.sv
// Port-level checker for legendre_series_kernel_entry, bound to the top level.
// Depends on legendre_series_kernel_entry_defines.svh.
`default_nettype none
`include "legendre_series_kernel_entry_defines.svh"
module lsk_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [47:0] rsp_entry,
   input wire logic        pready
);
   `LSK_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry), "stalled beat changed")
   `LSK_ASSERT_IMPL(a_ready_free, !rsp_valid, req_ready, "input blocked with empty output")
   `LSK_ASSERT_IMPL(a_ready_stall, rsp_valid && !rsp_ready, !req_ready, "input taken during stall")
   `LSK_ASSERT_IMPL(a_reset_clear, $past(reset), !rsp_valid && pready, "output valid after reset")
endmodule

bind legendre_series_kernel_entry lsk_port_checker u_lsk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_entry (rsp_entry),
   .pready    (pready)
);
`default_nettype wire

// File: sim/lsk_checker.sv
// Scoreboard for the Legendre series kernel entry: follows register writes,
// predicts each entry from the accepted request beat, and compares response beats.
// Depends on lsk_pkg only.
`default_nettype none
module lsk_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [31:0] req_first_x,
   input  wire logic signed [31:0] req_first_y,
   input  wire logic signed [31:0] req_first_z,
   input  wire logic signed [31:0] req_second_x,
   input  wire logic signed [31:0] req_second_y,
   input  wire logic signed [31:0] req_second_z,
   input  wire logic [31:0]        req_column_weight,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic signed [47:0] rsp_entry,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic               pready,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output int                      fail_count,
   output int                      entries_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_NUMBER_OF_TERMS = 3'd0;
   localparam longint     UNIT = 64'sd1 <<< 30;
   localparam longint     INV_4PI = 64'sd21361415;

   logic [5:0]     term_count;
   logic [47:0]    entry_queue[$];

   function automatic longint clamp_unit(longint v);
      if (v > UNIT) return UNIT;
      if (v < -UNIT) return -UNIT;
      return v;
   endfunction

   function automatic logic [47:0] predict_entry(lsk_pkg::in_bus_type b, logic [5:0] terms);
      longint dot, c, p1, p2, p, t, num, recip, total, m, wh, wl, e;
      int n;
      dot = ((longint'(b.ax) * longint'(b.bx)) >>> 2)
          + ((longint'(b.ay) * longint'(b.by)) >>> 2)
          + ((longint'(b.az) * longint'(b.bz)) >>> 2);
      c = clamp_unit((dot + (64'sd1 <<< 27)) >>> 28);
      n = (terms > 6'd32) ? 32 : int'(terms);
      p2 = UNIT;
      p1 = c;
      total = p1 + p2;
      for (int l = 2; l < n; l++) begin
         t = (c * p1 + (64'sd1 <<< 29)) >>> 30;
         num = longint'(2 * l - 1) * t - longint'(l - 1) * p2;
         recip = ((64'sd1 <<< 25) + longint'(l / 2)) / longint'(l);
         p = clamp_unit((num * recip + (64'sd1 <<< 24)) >>> 25);
         total += p;
         p2 = p1;
         p1 = p;
      end
      m = (total * INV_4PI + (64'sd1 <<< 25)) >>> 26;
      wh = longint'({32'd0, b.w} >> 16);
      wl = longint'({48'd0, b.w[15:0]});
      e = (m * wh + ((m * wl) >>> 16) + 64'sd4096) >>> 13;
      if (e > lsk_pkg::ENTRY_MAX) e = lsk_pkg::ENTRY_MAX;
      if (e < lsk_pkg::ENTRY_MIN) e = lsk_pkg::ENTRY_MIN;
      return e[47:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   assign entries_pending = entry_queue.size();

   always_ff @(posedge clock) begin
      lsk_pkg::in_bus_type beat;
      logic [47:0] want;
      if (reset) begin
         term_count <= 6'd8;
         entry_queue.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == ADDR_NUMBER_OF_TERMS)
            term_count <= pwdata[5:0];
         if (rsp_valid && rsp_ready) begin
            if (entry_queue.size() == 0) begin
               report_mismatch("response beat with no entry expected");
            end else begin
               want = entry_queue.pop_front();
               if (rsp_entry !== want)
                  report_mismatch($sformatf("entry got %h want %h", rsp_entry, want));
            end
         end
         if (req_valid && req_ready) begin
            beat = '{req_first_x, req_first_y, req_first_z,
                     req_second_x, req_second_y, req_second_z, req_column_weight};
            entry_queue.push_back(predict_entry(beat, term_count));
         end
      end
   end
endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Top of the Legendre series kernel entry testbench: clock, reset, register
// writes, request stimulus, response back-pressure and the verdict.
// Depends on lsk_pkg, legendre_series_kernel_entry and lsk_checker.
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ADDR_NUMBER_OF_TERMS = 3'd0;
   localparam int         ONE = 1 << 30;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         DRAIN_CYCLES = 80;

   logic               clock, reset;
   logic               req_valid, req_ready;
   lsk_pkg::in_bus_type req_beat;
   logic               rsp_valid, rsp_ready;
   logic signed [47:0] rsp_entry;
   logic               psel, penable, pwrite, pready;
   logic [2:0]         paddr;
   logic [31:0]        pwdata, prdata;
   int                 fail_count, entries_pending;
   logic               req_took;
   bit                 hold_off;
   int                 idle_cycles;

   legendre_series_kernel_entry u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_x(req_beat.ax), .req_first_y(req_beat.ay), .req_first_z(req_beat.az),
      .req_second_x(req_beat.bx), .req_second_y(req_beat.by), .req_second_z(req_beat.bz),
      .req_column_weight(req_beat.w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_entry(rsp_entry),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lsk_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_first_x(req_beat.ax), .req_first_y(req_beat.ay), .req_first_z(req_beat.az),
      .req_second_x(req_beat.bx), .req_second_y(req_beat.by), .req_second_z(req_beat.bz),
      .req_column_weight(req_beat.w),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_entry(rsp_entry),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata),
      .fail_count(fail_count), .entries_pending(entries_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always_ff @(posedge clock) req_took <= req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (250) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_ready = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(20, 60)) @(negedge clock);
         end else begin
            repeat ($urandom_range(1, 8)) @(negedge clock);
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
      end
   end

   task automatic write_terms(logic [5:0] terms);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = ADDR_NUMBER_OF_TERMS; pwdata = {$urandom} & ~32'h3f | terms;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic send_beat(lsk_pkg::in_bus_type b);
      int gap;
      req_beat = b;
      req_valid = 1'b1;
      do @(negedge clock); while (!req_took);
      gap = gap_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic int coord_any();
      return int'($urandom_range(0, 32'h8000_0000)) - ONE;
   endfunction

   function automatic int coord_of(real v);
      return $rtoi(v * 1073741824.0);
   endfunction

   function automatic lsk_pkg::in_bus_type random_beat();
      lsk_pkg::in_bus_type b;
      real th1, ph1, th2, ph2;
      int pick;
      pick = $urandom_range(0, 9);
      th1 = $urandom_range(0, 100000) * 3.14159265 / 100000.0;
      ph1 = $urandom_range(0, 100000) * 6.28318531 / 100000.0;
      th2 = $urandom_range(0, 100000) * 3.14159265 / 100000.0;
      ph2 = $urandom_range(0, 100000) * 6.28318531 / 100000.0;
      b.ax = coord_of($sin(th1) * $cos(ph1));
      b.ay = coord_of($sin(th1) * $sin(ph1));
      b.az = coord_of($cos(th1));
      b.bx = coord_of($sin(th2) * $cos(ph2));
      b.by = coord_of($sin(th2) * $sin(ph2));
      b.bz = coord_of($cos(th2));
      if (pick == 0) begin
         b.bx = b.ax; b.by = b.ay; b.bz = b.az;
      end else if (pick == 1) begin
         b.bx = -b.ax; b.by = -b.ay; b.bz = -b.az;
      end else if (pick >= 8) begin
         b.ax = coord_any(); b.ay = coord_any(); b.az = coord_any();
         b.bx = coord_any(); b.by = coord_any(); b.bz = coord_any();
      end
      case ($urandom_range(0, 4))
         0: b.w = 32'hFFFF_FFFF;
         1: b.w = $urandom_range(0, 32'hFFFF);
         default: b.w = $urandom;
      endcase
      return b;
   endfunction

   task automatic send_directed();
      lsk_pkg::in_bus_type b;
      int v[6][6];
      v = '{'{ONE, 0, 0, ONE, 0, 0},
            '{ONE, 0, 0, -ONE, 0, 0},
            '{0, ONE, 0, 0, 0, ONE},
            '{-ONE, -ONE, -ONE, -ONE, -ONE, -ONE},
            '{ONE, ONE, ONE, -ONE, -ONE, -ONE},
            '{0, 0, -ONE, 0, 0, -ONE}};
      foreach (v[i]) begin
         b = '{v[i][0], v[i][1], v[i][2], v[i][3], v[i][4], v[i][5], 32'hFFFF_FFFF};
         send_beat(b);
         b.w = (i % 2) ? 32'd0 : 32'h2000_0000;
         send_beat(b);
      end
      b = '{0, 0, 0, 0, 0, 0, 32'h8000_0001};
      send_beat(b);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (entries_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [5:0] terms[$];
      terms = '{6'd8, 6'd2, 6'd0, 6'd1, 6'd32, 6'd63, 6'd40, 6'd17, 6'd5, 6'd33};
      reset = 1'b1;
      req_valid = 1'b0;
      req_beat = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      hold_off = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);
      send_directed();
      foreach (terms[p]) begin
         wait_drained();
         write_terms(terms[p]);
         if (terms[p] == 6'd32) hold_off = 1'b1;
         if (p < 3) send_directed();
         repeat (40) send_beat(random_beat());
      end
      wait_drained();
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
+incdir+hw/rtl
hw/rtl/lsk_pkg.sv
hw/rtl/lsk_dot.sv
hw/rtl/lsk_term.sv
hw/rtl/lsk_scale.sv
hw/rtl/legendre_series_kernel_entry.sv
hw/rtl/lsk_checker.sv
sim/lsk_checker.sv
sim/tb_top.sv
